[rtl/midi_track_channel_rewriter_defines.svh]
// Assertion macros used by the checker file of this block.
`ifndef MIDI_TRACK_CHANNEL_REWRITER_DEFINES_SVH
`define MIDI_TRACK_CHANNEL_REWRITER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define MTCR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MTCR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that is also checked around reset.
`define MTCR_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/mtcr_pkg.sv]
`default_nettype none

package mtcr_pkg;

  localparam int DELTA_BYTES_MAX = 4;
  localparam int LEN_BYTES_MAX   = 4;
  localparam int FIFO_DEPTH      = 8;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
  localparam int COUNT_W         = 3;
  localparam int LEFT_W          = 28;

  // Upper nibbles of the channel voice statuses.
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CONTROL    = 4'hB;
  localparam logic [3:0] ST_PROGRAM    = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;

  localparam logic [7:0] META_STATUS       = 8'hFF;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

  typedef enum logic [6:0] {
    PH_DELTA     = 7'b0000001,
    PH_STATUS    = 7'b0000010,
    PH_DATA      = 7'b0000100,
    PH_SKIP      = 7'b0001000,
    PH_META_TYPE = 7'b0010000,
    PH_META_LEN  = 7'b0100000,
    PH_META_BODY = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    RC_NORMAL = 2'd0,
    RC_END    = 2'd1,
    RC_ERROR  = 2'd2
  } rc_t;

  typedef struct packed {
    logic [7:0] data;
    rc_t        code;
    logic       last;
  } entry_t;

  // Request from the parser to the result queue for one input transfer.
  typedef struct packed {
    logic   discard;  // drop entries not yet committed
    logic   write;    // append the entry
    logic   commit;   // make every appended entry visible to the reader
    entry_t entry;
  } fifo_req_t;

endpackage

`default_nettype wire

[rtl/mtcr_if.sv]
`default_nettype none

interface mtcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_track;

  modport source (output valid, output in_byte, output start_of_track, input ready);
  modport sink   (input valid, input in_byte, input start_of_track, output ready);
endinterface

interface mtcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_code;
  logic       last_in_run;

  modport source (output valid, output out_byte, output result_code, output last_in_run,
                  input ready);
  modport sink   (input valid, input out_byte, input result_code, input last_in_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/mtcr_parser.sv]
`default_nettype none

module mtcr_parser import mtcr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_of_track,
  output fifo_req_t       req
);

  logic [3:0]        target_channel;
  phase_t            phase, phase_next, cur_phase;
  logic [COUNT_W-1:0] delta_count, count_next, cur_count, count_inc;
  logic [LEFT_W-1:0]  bytes_left, left_next, cur_left;
  logic              end_meta_seen, end_next, cur_end;
  logic              halted, halted_next, cur_halted;
  logic [3:0]        hi;

  assign hi = in_byte[7:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_channel <= '0;
    end else if (cfg_wr_en) begin
      target_channel <= cfg_wr_data;
    end
  end

  always_comb begin
    cur_phase  = start_of_track ? PH_DELTA : phase;
    cur_count  = start_of_track ? '0 : delta_count;
    cur_left   = start_of_track ? '0 : bytes_left;
    cur_end    = start_of_track ? 1'b0 : end_meta_seen;
    cur_halted = start_of_track ? 1'b0 : halted;
    count_inc  = cur_count + COUNT_W'(1);

    phase_next  = cur_phase;
    count_next  = cur_count;
    left_next   = cur_left;
    end_next    = cur_end;
    halted_next = cur_halted;

    // A restart throws away any delta bytes still held in the queue.
    req.discard    = start_of_track;
    req.write      = 1'b0;
    req.commit     = 1'b0;
    req.entry.data = in_byte;
    req.entry.code = RC_NORMAL;
    req.entry.last = 1'b1;

    if (!cur_halted) begin
      case (cur_phase)
        PH_DELTA: begin
          // Delta bytes go into the queue but stay hidden until the status is known.
          req.write      = 1'b1;
          req.entry.last = 1'b0;
          count_next     = count_inc;
          if (!in_byte[7]) begin
            phase_next = PH_STATUS;
          end else if (count_inc >= COUNT_W'(DELTA_BYTES_MAX)) begin
            req.discard    = 1'b1;
            req.commit     = 1'b1;
            req.entry.code = RC_ERROR;
            req.entry.last = 1'b1;
            halted_next    = 1'b1;
            count_next     = '0;
          end
        end
        PH_STATUS: begin
          count_next = '0;
          if (hi inside {ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL, ST_CHAN_PRESS}
              || in_byte == META_STATUS) begin
            req.write  = 1'b1;
            req.commit = 1'b1;
            if (in_byte == META_STATUS) begin
              phase_next = PH_META_TYPE;
            end else begin
              req.entry.data = {hi, target_channel};
              left_next      = (hi == ST_CHAN_PRESS) ? LEFT_W'(1) : LEFT_W'(2);
              phase_next     = PH_DATA;
            end
          end else if (hi == ST_PROGRAM) begin
            req.discard = 1'b1;
            phase_next  = PH_SKIP;
          end else begin
            req.discard    = 1'b1;
            req.write      = 1'b1;
            req.commit     = 1'b1;
            req.entry.code = RC_ERROR;
            halted_next    = 1'b1;
          end
        end
        PH_DATA, PH_META_BODY: begin
          req.write  = 1'b1;
          req.commit = 1'b1;
          left_next  = cur_left - LEFT_W'(1);
          if (left_next == '0) begin
            phase_next = PH_DELTA;
          end
        end
        PH_SKIP: begin
          phase_next = PH_DELTA;
        end
        PH_META_TYPE: begin
          req.write  = 1'b1;
          req.commit = 1'b1;
          end_next   = (in_byte == META_END_OF_TRACK);
          left_next  = '0;
          count_next = '0;
          phase_next = PH_META_LEN;
        end
        PH_META_LEN: begin
          req.write  = 1'b1;
          req.commit = 1'b1;
          left_next  = {cur_left[LEFT_W-8:0], in_byte[6:0]};
          count_next = count_inc;
          if (!in_byte[7]) begin
            count_next = '0;
            if (cur_end) begin
              req.entry.code = RC_END;
              halted_next    = 1'b1;
              phase_next     = PH_DELTA;
            end else begin
              phase_next = (left_next == '0) ? PH_DELTA : PH_META_BODY;
            end
          end else if (count_inc >= COUNT_W'(LEN_BYTES_MAX)) begin
            req.entry.code = RC_ERROR;
            halted_next    = 1'b1;
            count_next     = '0;
          end
        end
        default: begin
          phase_next = PH_DELTA;
          count_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DELTA;
      delta_count   <= '0;
      bytes_left    <= '0;
      end_meta_seen <= 1'b0;
      halted        <= 1'b0;
    end else if (take) begin
      phase         <= phase_next;
      delta_count   <= count_next;
      bytes_left    <= left_next;
      end_meta_seen <= end_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

[rtl/mtcr_out_fifo.sv]
`default_nettype none

module mtcr_out_fifo import mtcr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      take,
  input  wire fifo_req_t req,
  output logic           has_room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output entry_t         out_entry
);

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr, commit_ptr, rd_ptr;
  logic [FIFO_AW:0]   base, wr_ptr_next, commit_next;

  // Entries between commit_ptr and wr_ptr are held back from the reader.
  always_comb begin
    base        = req.discard ? commit_ptr : wr_ptr;
    wr_ptr_next = base + (FIFO_AW+1)'(req.write);
    commit_next = req.commit ? wr_ptr_next : commit_ptr;
  end

  assign has_room  = (wr_ptr - rd_ptr) != (FIFO_AW+1)'(FIFO_DEPTH);
  assign out_valid = rd_ptr != commit_ptr;
  assign out_entry = mem[rd_ptr[FIFO_AW-1:0]];

  always_ff @(posedge clk) begin
    if (take && req.write) begin
      mem[base[FIFO_AW-1:0]] <= req.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      commit_ptr <= '0;
      rd_ptr     <= '0;
    end else begin
      if (take) begin
        wr_ptr     <= wr_ptr_next;
        commit_ptr <= commit_next;
      end
      if (out_valid && out_ready) begin
        rd_ptr <= rd_ptr + (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/midi_track_channel_rewriter.sv]
// Channel  Direction  Payload
// in_ch    sink       in_byte[7:0], start_of_track
// out_ch   source     out_byte[7:0], result_code[1:0], last_in_run
// cfg      write      cfg_wr_data[3:0] (target channel), cfg_wr_en
//
// One input byte is taken every cycle while the eight-entry result queue has a free slot;
// its results are registered in the queue and shown to the reader once committed.
// Held delta bytes sit in the queue uncommitted, so a kept event's results appear together.
// An output stall only backs up the queue; the input stalls once the queue is full.
// Synchronous reset empties the queue and returns the parser to expect a delta time.
`default_nettype none

module midi_track_channel_rewriter import mtcr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  mtcr_in_if.sink         in_ch,
  mtcr_out_if.source      out_ch
);

  fifo_req_t req;
  entry_t    out_entry;
  logic      has_room;
  logic      take;

  assign take        = in_ch.valid && has_room;
  assign in_ch.ready = has_room;

  mtcr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .take           (take),
    .in_byte        (in_ch.in_byte),
    .start_of_track (in_ch.start_of_track),
    .req            (req)
  );

  mtcr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_entry (out_entry)
  );

  assign out_ch.out_byte    = out_entry.data;
  assign out_ch.result_code = out_entry.code;
  assign out_ch.last_in_run = out_entry.last;

endmodule

`default_nettype wire

[rtl/mtcr_checker.sv]
`default_nettype none
`include "midi_track_channel_rewriter_defines.svh"

module mtcr_checker import mtcr_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] result_code,
  input wire logic       last_in_run
);

  // The queue is empty right after reset.
  `MTCR_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(rst), !out_valid, "result shown after reset")

  // A stalled result keeps its payload.
  `MTCR_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(result_code) && $stable(last_in_run), "stalled result changed")

  // End of track and errors always close the run of their input byte.
  `MTCR_ASSERT_SAME(a_flag_is_last, clk, rst, out_valid && (result_code == RC_END || result_code == RC_ERROR), last_in_run, "flagged result not last in run")

  // The unused result code never appears.
  `MTCR_ASSERT_SAME(a_code_known, clk, rst, out_valid, result_code != 2'd3, "unknown result code")

endmodule

bind midi_track_channel_rewriter mtcr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .result_code (out_ch.result_code),
  .last_in_run (out_ch.last_in_run)
);

`default_nettype wire
